// ===== hw/rtl/qpd_pkg.sv =====
package qpd_pkg;

  // Width of the running decoded-byte counter (8 to 32).
  localparam int LENGTH_BITS = 16;
  localparam int OUT_LENGTH_BITS = 16;

  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_VT      = 8'h0B;
  localparam logic [7:0] CHAR_FF      = 8'h0C;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_0       = 8'h30;
  localparam logic [7:0] CHAR_9       = 8'h39;
  localparam logic [7:0] CHAR_EQ      = 8'h3D;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;

  typedef enum logic [1:0] {
    MODE_NORMAL     = 2'd0,
    MODE_AFTER_EQ   = 2'd1,
    MODE_AFTER_CR   = 2'd2,
    MODE_HAVE_FIRST = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]                 out_byte;
    logic                       byte_valid;
    logic                       end_of_message;
    logic                       truncated_escape;
    logic [OUT_LENGTH_BITS-1:0] decoded_length;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_value(input logic [7:0] c);
    hex_digit_t d;
    d.ok  = 1'b1;
    d.val = 4'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      d.val = 4'(c - CHAR_0);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
      d.val = 4'(c - CHAR_LOWER_A + 8'd10);
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      d.val = 4'(c - CHAR_UPPER_A + 8'd10);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    logic sp;
    sp = (c inside {CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR});
    return sp;
  endfunction

  // Saturate the internal counter to the 16-bit reported length.
  function automatic logic [OUT_LENGTH_BITS-1:0] sat_length(
    input logic [LENGTH_BITS-1:0] count
  );
    logic [32:0] wide;
    logic [32:0] limit;
    wide  = 33'(count);
    limit = 33'({OUT_LENGTH_BITS{1'b1}});
    return (wide > limit) ? {OUT_LENGTH_BITS{1'b1}} : wide[OUT_LENGTH_BITS-1:0];
  endfunction

endpackage

// ===== hw/rtl/qpd_in_if.sv =====
interface qpd_in_if;
  import qpd_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/qpd_out_if.sv =====
interface qpd_out_if;
  import qpd_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/qpd_hex_parse.sv =====
// Two-character strtoul-style hex parse, result modulo 256.
module qpd_hex_parse (
  input  logic [7:0] c0,
  input  logic [7:0] c1,
  output logic [7:0] value
);
  import qpd_pkg::*;

  hex_digit_t d0;
  hex_digit_t d1;

  assign d0 = hex_value(c0);
  assign d1 = hex_value(c1);

  always_comb begin
    value = 8'd0;
    if (is_space(c0) || c0 == CHAR_PLUS) begin
      value = d1.ok ? {4'd0, d1.val} : 8'd0;
    end else if (c0 == CHAR_MINUS) begin
      value = d1.ok ? 8'(8'd0 - {4'd0, d1.val}) : 8'd0;
    end else if (!d0.ok) begin
      value = 8'd0;
    end else if (!d1.ok) begin
      value = {4'd0, d0.val};
    end else begin
      value = {d0.val, d1.val};
    end
  end
endmodule

// ===== hw/rtl/qpd_decode.sv =====
// Escape state machine and length counter; state moves on advance.
module qpd_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  qpd_pkg::in_item_t item,
  output logic              has_result,
  output qpd_pkg::result_t  result
);
  import qpd_pkg::*;

  mode_t                  mode;
  mode_t                  mode_next;
  logic [7:0]             first_escape_char;
  logic [7:0]             first_escape_char_next;
  logic [LENGTH_BITS-1:0] byte_count;
  logic [LENGTH_BITS-1:0] byte_count_next;
  logic [LENGTH_BITS-1:0] count_inc;
  logic [7:0]             parsed;
  logic [7:0]             dec_byte;
  logic                   emit;
  mode_t                  mode_after;

  qpd_hex_parse u_hex_parse (
    .c0    (first_escape_char),
    .c1    (item.in_byte),
    .value (parsed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_NORMAL;
      first_escape_char <= 8'd0;
      byte_count        <= '0;
    end else if (advance) begin
      mode              <= mode_next;
      first_escape_char <= first_escape_char_next;
      byte_count        <= byte_count_next;
    end
  end

  always_comb begin
    mode_after             = mode;
    first_escape_char_next = first_escape_char;
    emit                   = 1'b0;
    dec_byte               = 8'd0;
    case (mode)
      MODE_NORMAL: begin
        if (item.in_byte == CHAR_EQ) begin
          mode_after = MODE_AFTER_EQ;
        end else begin
          emit     = 1'b1;
          dec_byte = item.in_byte;
        end
      end
      MODE_AFTER_EQ: begin
        if (item.in_byte == CHAR_CR) begin
          mode_after = MODE_AFTER_CR;
        end else if (item.in_byte == CHAR_LF) begin
          mode_after = MODE_NORMAL;
        end else begin
          first_escape_char_next = item.in_byte;
          mode_after             = MODE_HAVE_FIRST;
        end
      end
      MODE_AFTER_CR: begin
        if (item.in_byte == CHAR_LF) begin
          mode_after = MODE_NORMAL;
        end else begin
          first_escape_char_next = item.in_byte;
          mode_after             = MODE_HAVE_FIRST;
        end
      end
      MODE_HAVE_FIRST: begin
        emit       = 1'b1;
        dec_byte   = parsed;
        mode_after = MODE_NORMAL;
      end
      default: begin
        mode_after = MODE_NORMAL;
      end
    endcase

    count_inc = (emit && byte_count != {LENGTH_BITS{1'b1}}) ?
                byte_count + LENGTH_BITS'(1) : byte_count;

    has_result               = emit || item.last;
    result.out_byte          = dec_byte;
    result.byte_valid        = emit;
    result.end_of_message    = item.last;
    result.truncated_escape  = item.last && (mode_after != MODE_NORMAL);
    result.decoded_length    = item.last ? sat_length(count_inc) : '0;

    // End of message returns everything to reset values.
    if (item.last) begin
      mode_next              = MODE_NORMAL;
      first_escape_char_next = 8'd0;
      byte_count_next        = '0;
    end else begin
      mode_next       = mode_after;
      byte_count_next = count_inc;
    end
  end
endmodule

// ===== hw/rtl/quoted_printable_decoder.sv =====
// Quoted-printable decoder.
//
// item   : sink channel, one encoded byte per transfer plus a last flag that
//          marks the final byte of a message.
// result : source channel, zero or one transfer per input byte. Plain bytes
//          and completed "=XY" escapes give a decoded byte; '=' and soft
//          line breaks ("=LF", "=CRLF") give nothing. The last byte always
//          gives a transfer with end_of_message, the saturated decoded
//          length and a flag if an escape was cut off by the end.
//
// An input transfer reaches its result through the input register, then
// decode into the result register. Throughput: one byte per cycle while
// the receiver does not stall.
//
// Reset (rst, synchronous) empties both registers and returns the decoder
// to pass-through mode with a zero count. When the receiver stalls, the
// result register holds; one more byte is taken into the input register,
// after which item.ready drops until the result moves.
module quoted_printable_decoder (
  input logic     clk,
  input logic     rst,
  qpd_in_if.sink  item,
  qpd_out_if.source result
);
  import qpd_pkg::*;

  // Input register
  logic     s_valid;
  in_item_t s_item;

  // Result register
  logic     o_valid;
  result_t  o_data;

  logic     advance;      // staged byte is decoded this cycle
  logic     out_free;     // result register can take a new value
  logic     has_result;
  result_t  dec_result;

  assign out_free   = !o_valid || result.ready;
  assign advance    = s_valid && out_free;
  assign item.ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (item.ready) begin
      s_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s_item <= item.data;
    end
  end

  qpd_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item       (s_item),
    .has_result (has_result),
    .result     (dec_result)
  );

  // Bytes that decode to nothing just drop out of the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_free) begin
      o_valid <= advance && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      o_data <= dec_result;
    end
  end

  assign result.valid = o_valid;
  assign result.data  = o_data;

  // Every result carries a byte or closes a message.
  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (o_data.byte_valid || o_data.end_of_message))
    else $error("result with neither byte nor end of message");

  // Length and truncation fields only appear on end of message.
  a_eom_fields: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !o_data.end_of_message) |->
      (!o_data.truncated_escape && o_data.decoded_length == '0))
    else $error("end-of-message fields set on mid-message result");

  // A decoded last byte always lands in the result register.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (advance && s_item.last) |=> (o_valid && o_data.end_of_message))
    else $error("last byte produced no end-of-message result");

  // Input side only stalls with a full input register.
  a_ready_low_full: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (s_valid && o_valid && !result.ready))
    else $error("input stalled without backpressure");
endmodule
